>>> design/stable_priority_queue_table_macros.svh
// Assertion macros shared by the stable priority queue table.
`ifndef STABLE_PRIORITY_QUEUE_TABLE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SPQT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPQT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/spqt_pkg.sv
// Shared constants and types for the stable priority queue table.
package spqt_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int ID_BITS_DEF  = 16;

    localparam int PORT_ID_W = 16;
    localparam int PRIO_W    = 2;
    localparam int POS_W     = 4;
    localparam int STATUS_W  = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOMATCH = 2'd2;

    localparam logic [PRIO_W-1:0] PRIO_ZERO = 2'd0;
    localparam logic [PRIO_W-1:0] PRIO_TOP  = 2'd1;

    // Per-cycle commands broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;    // insert the broadcast entry
        logic rem;    // remove the first matching entry
        logic load;   // copy the table into the readout chain
        logic shift;  // advance the readout chain by one cell
    } spqt_ctrl_t;

endpackage

>>> design/spqt_cell.sv
// One table cell: a stored entry plus its readout shadow.
module spqt_cell
    import spqt_pkg::*;
#(
    parameter int ID_W = ID_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  spqt_ctrl_t        ctrl_i,
    input  logic [ID_W-1:0]   new_id_i,
    input  logic [PRIO_W-1:0] new_pr_i,
    input  logic              left_stay_i,
    input  logic              left_seen_i,
    input  logic              left_valid_i,
    input  logic [ID_W-1:0]   left_id_i,
    input  logic [PRIO_W-1:0] left_pr_i,
    input  logic              right_valid_i,
    input  logic [ID_W-1:0]   right_id_i,
    input  logic [PRIO_W-1:0] right_pr_i,
    input  logic              right_sh_valid_i,
    input  logic [ID_W-1:0]   right_sh_id_i,
    input  logic [PRIO_W-1:0] right_sh_pr_i,
    output logic              stay_o,
    output logic              seen_o,
    output logic              valid_o,
    output logic [ID_W-1:0]   id_o,
    output logic [PRIO_W-1:0] pr_o,
    output logic              sh_valid_o,
    output logic [ID_W-1:0]   sh_id_o,
    output logic [PRIO_W-1:0] sh_pr_o
);

    logic              valid_reg, valid_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [PRIO_W-1:0] pr_reg, pr_next;
    logic              sh_valid_reg, sh_valid_next;
    logic [ID_W-1:0]   sh_id_reg, sh_id_next;
    logic [PRIO_W-1:0] sh_pr_reg, sh_pr_next;
    logic              match;

    always_comb begin
        stay_o = valid_reg && (pr_reg <= new_pr_i);
        match  = valid_reg && (id_reg == new_id_i) && (pr_reg == new_pr_i);
        seen_o = left_seen_i | match;

        valid_next = valid_reg;
        id_next    = id_reg;
        pr_next    = pr_reg;
        if (ctrl_i.ins) begin
            // everything past the insertion point moves one cell right
            if (!left_stay_i) begin
                valid_next = left_valid_i;
                id_next    = left_id_i;
                pr_next    = left_pr_i;
            end else if (!stay_o) begin
                valid_next = 1'b1;
                id_next    = new_id_i;
                pr_next    = new_pr_i;
            end
        end else if (ctrl_i.rem && seen_o) begin
            // close the gap left by the removed entry
            valid_next = right_valid_i;
            id_next    = right_id_i;
            pr_next    = right_pr_i;
        end

        sh_valid_next = sh_valid_reg;
        sh_id_next    = sh_id_reg;
        sh_pr_next    = sh_pr_reg;
        if (ctrl_i.load) begin
            sh_valid_next = valid_reg;
            sh_id_next    = id_reg;
            sh_pr_next    = pr_reg;
        end else if (ctrl_i.shift) begin
            sh_valid_next = right_sh_valid_i;
            sh_id_next    = right_sh_id_i;
            sh_pr_next    = right_sh_pr_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            sh_valid_reg <= 1'b0;
        end else begin
            valid_reg    <= valid_next;
            sh_valid_reg <= sh_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg    <= id_next;
        pr_reg    <= pr_next;
        sh_id_reg <= sh_id_next;
        sh_pr_reg <= sh_pr_next;
    end

    assign valid_o    = valid_reg;
    assign id_o       = id_reg;
    assign pr_o       = pr_reg;
    assign sh_valid_o = sh_valid_reg;
    assign sh_id_o    = sh_id_reg;
    assign sh_pr_o    = sh_pr_reg;

endmodule

>>> design/stable_priority_queue_table.sv
// Stable priority queue table: a chain of cells holding entries sorted by priority, arrival
// order kept within a priority. Each input beat (tuser = command: insert or remove) updates
// the chain in the cycle it is accepted; the next cycle copies the chain into a readout
// shadow, which then shifts out one entry per cycle while the output is not stalled. An
// operation returns N result beats, N being the occupancy capped at 16, at least one.
// An insert into a full table is dropped and a remove with no match leaves the table as
// it was; both are reported in op_status on every beat. An empty table answers with one
// beat, present 0.
module stable_priority_queue_table
    import spqt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int ID_BITS  = ID_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // entry_id[15:0], entry_priority[17:16], zero pad
    input  logic [0:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // position[3:0], out_id[19:4], out_priority[21:20],
                                   // present[22], op_status[24:23], zero pad
    output logic        m_tlast
);

    localparam int SW = (ID_BITS < PORT_ID_W) ? ID_BITS : PORT_ID_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOAD   = 2'd1;
    localparam logic [1:0] ST_STREAM = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [31:0]         m_tdata_reg, m_tdata_next;
    logic                m_tlast_reg, m_tlast_next;

    spqt_ctrl_t        ctrl;
    logic              accept;
    logic              full;
    logic              found;
    logic              out_free;
    logic              last_beat;
    logic [SW-1:0]     new_id;
    logic [PRIO_W-1:0] new_pr;
    logic [PORT_ID_W-1:0] beat_id;
    logic [PRIO_W-1:0]    beat_pr;

    // chain links; index i is the boundary on the left of cell i
    logic              stay  [CAPACITY+1];
    logic              seen  [CAPACITY+1];
    logic              valid [CAPACITY+2];
    logic [SW-1:0]     ids   [CAPACITY+2];
    logic [PRIO_W-1:0] prs   [CAPACITY+2];
    logic              shv   [CAPACITY+1];
    logic [SW-1:0]     shid  [CAPACITY+1];
    logic [PRIO_W-1:0] shpr  [CAPACITY+1];
    logic [CAPACITY:0] valid_vec;

    // slot 0 and slot CAPACITY+1 of the data arrays are the empty ends of the chain
    assign stay[0]            = 1'b1;
    assign seen[0]            = 1'b0;
    assign valid[0]           = 1'b0;
    assign ids[0]             = '0;
    assign prs[0]             = '0;
    assign valid[CAPACITY+1]  = 1'b0;
    assign ids[CAPACITY+1]    = '0;
    assign prs[CAPACITY+1]    = '0;
    assign shv[CAPACITY]      = 1'b0;
    assign shid[CAPACITY]     = '0;
    assign shpr[CAPACITY]     = '0;

    assign new_id = s_tdata[SW-1:0];
    assign new_pr = (s_tdata[17:16] == PRIO_ZERO) ? PRIO_TOP : s_tdata[17:16];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        spqt_cell #(
            .ID_W(SW)
        ) u_cell (
            .aclk            (aclk),
            .aresetn         (aresetn),
            .ctrl_i          (ctrl),
            .new_id_i        (new_id),
            .new_pr_i        (new_pr),
            .left_stay_i     (stay[i]),
            .left_seen_i     (seen[i]),
            .left_valid_i    (valid[i]),
            .left_id_i       (ids[i]),
            .left_pr_i       (prs[i]),
            .right_valid_i   (valid[i+2]),
            .right_id_i      (ids[i+2]),
            .right_pr_i      (prs[i+2]),
            .right_sh_valid_i(shv[i+1]),
            .right_sh_id_i   (shid[i+1]),
            .right_sh_pr_i   (shpr[i+1]),
            .stay_o          (stay[i+1]),
            .seen_o          (seen[i+1]),
            .valid_o         (valid[i+1]),
            .id_o            (ids[i+1]),
            .pr_o            (prs[i+1]),
            .sh_valid_o      (shv[i]),
            .sh_id_o         (shid[i]),
            .sh_pr_o         (shpr[i])
        );
        assign valid_vec[i] = valid[i+1];
    end
    assign valid_vec[CAPACITY] = 1'b0;

    assign full      = valid[CAPACITY];
    assign found     = seen[CAPACITY];
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign last_beat = (pos_reg == {POS_W{1'b1}}) || !shv[1];
    assign beat_id   = shv[0] ? PORT_ID_W'(shid[0]) : '0;
    assign beat_pr   = shv[0] ? shpr[0] : '0;

    always_comb begin
        ctrl.ins   = accept && (s_tuser[0] == CMD_INSERT) && !full;
        ctrl.rem   = accept && (s_tuser[0] == CMD_REMOVE);
        ctrl.load  = (state_reg == ST_LOAD);
        ctrl.shift = (state_reg == ST_STREAM) && out_free;

        state_next    = state_reg;
        status_next   = status_reg;
        pos_next      = pos_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser[0] == CMD_INSERT) begin
                        status_next = full ? STATUS_FULL : STATUS_DONE;
                    end else begin
                        status_next = found ? STATUS_DONE : STATUS_NOMATCH;
                    end
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                pos_next   = '0;
                state_next = ST_STREAM;
            end
            ST_STREAM: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'd0, status_reg, shv[0], beat_pr, beat_id, pos_reg};
                    m_tlast_next  = last_beat;
                    pos_next      = pos_reg + 1'b1;
                    if (last_beat) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg  <= status_next;
        pos_reg     <= pos_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`include "stable_priority_queue_table_macros.svh"

    `SPQT_ASSERT_NOW(a_occupied_prefix, 1'b1, $onehot(valid_vec + 1'b1), "table cells not contiguous")
    `SPQT_ASSERT_NEXT(a_accept_loads, accept, state_reg == ST_LOAD, "accept not followed by load")
    `SPQT_ASSERT_NEXT(a_load_streams, state_reg == ST_LOAD, state_reg == ST_STREAM, "load not followed by stream")
    `SPQT_ASSERT_NOW(a_empty_is_last, m_tvalid_reg && !m_tdata_reg[22], m_tlast_reg, "empty beat not last")

endmodule
